@@ rtl/ira_pkg.sv @@
// ----------------------------------------------------------------------------
// ira_pkg
// shared types for the interval room allocator: controller states and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int unsigned OUT_BITS = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } ira_state_e;

  typedef struct packed {
    logic load;    // capture request, restart scan
    logic issue;   // read next room entry
    logic commit;  // update room table, load result register
  } ira_cmd_t;

  typedef struct packed {
    logic scan_done;   // every opened room has been read
    logic can_commit;  // result register free or being drained
  } ira_status_t;

endpackage

@@ rtl/interval_room_allocator.sv @@
// timing: each accepted transaction is answered after a sweep over the n
//   rooms open when the sweep starts, a commit, and any result stall
// intake: no new transaction is taken until the current one is committed;
//   the sweep over the room table does one memory read a cycle
// reset: rst_ni asynchronous active low clears the room count, the
//   controller and the result valid; the room table is not cleared
// ----------------------------------------------------------------------------
// interval_room_allocator
// greedy room allocator: reuse the room that frees earliest, else open a new
// room, flag overflow when every room is in use
// ----------------------------------------------------------------------------
module interval_room_allocator import ira_pkg::*; #(
  parameter int unsigned MAX_ROOMS = 256,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [31:0]         arrival_time_i,
  input  logic [31:0]         departure_time_i,
  input  logic [15:0]         request_tag_i,
  input  logic                new_batch_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_BITS-1:0] assigned_room_o,
  output logic [15:0]         result_tag_o,
  output logic [OUT_BITS-1:0] rooms_opened_o,
  output logic                overflow_o
);

  ira_cmd_t    cmd;
  ira_status_t status;

  // sequencer: idle, sweep of the opened rooms, commit
  ira_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // room table, minimum search, result register
  ira_datapath #(
    .MAX_ROOMS (MAX_ROOMS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .arrival_time_i   (arrival_time_i),
    .departure_time_i (departure_time_i),
    .request_tag_i    (request_tag_i),
    .new_batch_i      (new_batch_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .assigned_room_o  (assigned_room_o),
    .result_tag_o     (result_tag_o),
    .rooms_opened_o   (rooms_opened_o),
    .overflow_o       (overflow_o)
  );

`ifndef SYNTHESIS
  // overflow results carry no room
  a_ovf_no_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> assigned_room_o == '0)
    else $error("overflow result with a room");

  // a granted room never lies above the opened count
  a_room_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_o && (MAX_ROOMS < 512) |->
      (assigned_room_o != '0) && (assigned_room_o <= rooms_opened_o))
    else $error("room outside opened range");

  // overflow only once every room is open
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o && (MAX_ROOMS < 512) |->
      rooms_opened_o == OUT_BITS'(MAX_ROOMS))
    else $error("overflow before all rooms open");
`endif

endmodule

@@ rtl/ira_ctrl.sv @@
// ----------------------------------------------------------------------------
// ira_ctrl
// sequencer: accept a request, sweep the opened rooms, then commit
// ----------------------------------------------------------------------------
module ira_ctrl import ira_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ira_status_t status_i,
  output ira_cmd_t    cmd_o
);

  ira_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_FIN: begin
        if (status_i.can_commit) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/ira_datapath.sv @@
// ----------------------------------------------------------------------------
// ira_datapath
// room table memory, running minimum search and result register
// ----------------------------------------------------------------------------
module ira_datapath import ira_pkg::*; #(
  parameter int unsigned MAX_ROOMS = 256,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ira_cmd_t            cmd_i,
  output ira_status_t         status_o,
  input  logic [31:0]         arrival_time_i,
  input  logic [31:0]         departure_time_i,
  input  logic [15:0]         request_tag_i,
  input  logic                new_batch_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_BITS-1:0] assigned_room_o,
  output logic [15:0]         result_tag_o,
  output logic [OUT_BITS-1:0] rooms_opened_o,
  output logic                overflow_o
);

  localparam int unsigned IW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROOMS + 1);

  logic [TIME_BITS-1:0] mem_q [MAX_ROOMS];

  logic [TIME_BITS-1:0] arr_q, dep_q, rd_data_q, best_val_q;
  logic [15:0]          tag_q;
  logic [CW-1:0]        cnt_q, idx_q;
  logic [IW-1:0]        rd_idx_q, best_idx_q;
  logic                 rd_vld_q;
  logic                 out_valid_q;
  logic [OUT_BITS-1:0]  room_q, opened_q;
  logic [15:0]          otag_q;
  logic                 ovf_q;

  logic [63:0]          arr_ext, dep_ext;
  logic                 reuse, room_left, wr_en;
  logic [IW-1:0]        wr_addr;
  logic [CW-1:0]        room_val, cnt_nxt;
  logic [31:0]          room_wide, cnt_wide;

  assign arr_ext = {32'd0, arrival_time_i};
  assign dep_ext = {32'd0, departure_time_i};

  assign status_o.scan_done  = (idx_q == cnt_q);
  assign status_o.can_commit = !out_valid_q || !out_stall_i;

  assign reuse     = (cnt_q != '0) && (best_val_q < arr_q);
  assign room_left = (cnt_q < CW'(MAX_ROOMS));
  assign wr_en     = cmd_i.commit && (reuse || room_left);
  assign wr_addr   = reuse ? best_idx_q : cnt_q[IW-1:0];
  assign cnt_nxt   = (!reuse && room_left) ? cnt_q + CW'(1) : cnt_q;
  assign room_val  = reuse ? CW'(best_idx_q) + CW'(1) :
                     (room_left ? cnt_q + CW'(1) : '0);
  assign room_wide = 32'(room_val);
  assign cnt_wide  = 32'(cnt_nxt);

  // room table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= dep_q;
    end
    rd_data_q <= mem_q[idx_q[IW-1:0]];
  end

  // request capture and minimum search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.load) begin
        idx_q <= '0;
        if (new_batch_i) begin
          cnt_q <= '0;
        end
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.commit) begin
        cnt_q <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_idx_q <= idx_q[IW-1:0];
    end
    if (cmd_i.load) begin
      arr_q <= arr_ext[TIME_BITS-1:0];
      dep_q <= dep_ext[TIME_BITS-1:0];
      tag_q <= request_tag_i;
    end
    // strict compare keeps the lowest room on ties
    if (rd_vld_q && ((rd_idx_q == '0) || (rd_data_q < best_val_q))) begin
      best_val_q <= rd_data_q;
      best_idx_q <= rd_idx_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      room_q   <= room_wide[OUT_BITS-1:0];
      opened_q <= cnt_wide[OUT_BITS-1:0];
      otag_q   <= tag_q;
      ovf_q    <= !reuse && !room_left;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign assigned_room_o = room_q;
  assign rooms_opened_o  = opened_q;
  assign result_tag_o    = otag_q;
  assign overflow_o      = ovf_q;

endmodule
